// ===== rtl/codo_pkg.sv =====
// ----------------------------------------------------------------------------
// codo_pkg: shared types and constants of the combination odometer
// Field widths, operation codes and the XYZ triple type used by the core
// and its arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package codo_pkg;

	// Width of one unsigned Q16.16 value.
	localparam int DATA_W   = 32;
	// Number of coordinates in one triple (X, Y and Z).
	localparam int LANES    = 3;
	localparam int LANE_W   = 2;

	// Fixed widths of the item fields and of the register.
	localparam int OP_W     = 2;
	localparam int CHAN_W   = 4;
	localparam int LEVEL_W  = 6;
	localparam int LIMIT_W  = 7;
	localparam int COUNT_W  = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_SET     = 2'd1;
	localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

	// Value of the channel count register after reset.
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

	// Lane 0 holds X, lane 1 holds Y, lane 2 holds Z.
	typedef logic [LANES-1:0][DATA_W-1:0] xyz_t;

endpackage

`default_nettype wire

// ===== rtl/codo_ram.sv =====
// ----------------------------------------------------------------------------
// codo_ram: generic single write port, single read port memory
// The read data is registered and holds while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module codo_ram #(
	parameter  int WIDTH  = 32,
	parameter  int DEPTH  = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                    clk,
	input  wire logic                    we,
	input  wire logic [ADDR_W-1:0]       waddr,
	input  wire logic [WIDTH-1:0]        wdata,
	input  wire logic                    re,
	input  wire logic [ADDR_W-1:0]       raddr,
	output      logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/codo_sat_add.sv =====
// ----------------------------------------------------------------------------
// codo_sat_add: unsigned saturating adder for one Q16.16 coordinate
// The sum clamps to all ones when the addition carries out.
// ----------------------------------------------------------------------------
`default_nettype none

module codo_sat_add (
	input  wire logic [codo_pkg::DATA_W-1:0] a,
	input  wire logic [codo_pkg::DATA_W-1:0] b,
	output      logic [codo_pkg::DATA_W-1:0] s
);

	logic [codo_pkg::DATA_W:0] full;

	assign full = {1'b0, a} + {1'b0, b};
	assign s    = full[codo_pkg::DATA_W] ? '1 : full[codo_pkg::DATA_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/combo_odometer_with_partial_sums_core.sv =====
// ----------------------------------------------------------------------------
// combo_odometer_with_partial_sums_core: mixed-radix odometer enumerator
// Steps through level combinations of the active channels and returns the
// saturated XYZ sum of each new combination, built from per-channel partial
// sums and a loaded table of per-level XYZ values.
// ----------------------------------------------------------------------------
// Sequence: a load, set or unused op item goes from idle to the finish state,
// then into the output register once it is free. An advance item scans the
// channels (one per cycle, from the last active channel down) until one can
// step, adds X, Y and Z in turn, then writes the new partial sum (one write
// per cycle) to each later active channel; a full wrap ends after the scan.
// Throughput: one item at a time; the next item is accepted once the result
// of the current one sits in the output register.
// Reset: arst_n clears the sequencer, output valid and found bits, the channel
// count (to 1) and the per-channel valid bits; the level table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module combo_odometer_with_partial_sums_core #(
	parameter int MAX_CHANNELS = 16,
	parameter int MAX_LEVELS   = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,

	// Configuration: number of active channels.
	input  wire logic                              cfg_wr_en,
	input  wire logic [codo_pkg::COUNT_W-1:0]      cfg_wr_data,

	// Request channel.
	input  wire logic                              req_valid,
	output      logic                              req_stall,
	input  wire logic [codo_pkg::OP_W-1:0]         op,
	input  wire logic [codo_pkg::CHAN_W-1:0]       channel,
	input  wire logic [codo_pkg::LEVEL_W-1:0]      level,
	input  wire logic [codo_pkg::LIMIT_W-1:0]      level_limit_in,
	input  wire logic [codo_pkg::DATA_W-1:0]       x_in,
	input  wire logic [codo_pkg::DATA_W-1:0]       y_in,
	input  wire logic [codo_pkg::DATA_W-1:0]       z_in,

	// Response channel.
	output      logic                              rsp_valid,
	input  wire logic                              rsp_stall,
	output      logic                              found,
	output      logic [codo_pkg::DATA_W-1:0]       sum_x,
	output      logic [codo_pkg::DATA_W-1:0]       sum_y,
	output      logic [codo_pkg::DATA_W-1:0]       sum_z
);

	// Width of a channel address, of a level index, and of a channel count
	// that can also hold MAX_CHANNELS itself.
	localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int LV_W   = $clog2(MAX_LEVELS);
	localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
	localparam int CTL_W  = codo_pkg::LIMIT_W + LV_W;
	localparam int TBL_AW = CH_W + LV_W;
	localparam int XYZ_W  = codo_pkg::LANES * codo_pkg::DATA_W;

	localparam logic [codo_pkg::LANE_W-1:0] LANE_LAST =
		codo_pkg::LANE_W'(codo_pkg::LANES - 1);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EVAL = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_COPY = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]                    state_q;
	logic [codo_pkg::COUNT_W-1:0]  count_q;
	logic [CNT_W-1:0]              n_q;
	logic [CH_W-1:0]               c_q;
	logic [CNT_W-1:0]              j_q;
	logic [codo_pkg::LANE_W-1:0]   lane_q;
	logic                          fnd_q;
	logic [MAX_CHANNELS-1:0]       ctl_vld_q;
	logic [MAX_CHANNELS-1:0]       sum_vld_q;
	codo_pkg::xyz_t                psum_q;
	codo_pkg::xyz_t                res_q;

	logic                          rsp_valid_q;
	logic                          rsp_found_q;
	codo_pkg::xyz_t                rsp_sum_q;

	// Decoded request.
	logic                          accept;
	logic                          ch_ok;
	logic                          lv_ok;
	logic [CH_W-1:0]               ch_idx;
	logic [LV_W-1:0]               set_idx;
	logic [CNT_W-1:0]              n_w;
	logic                          start_scan;
	codo_pkg::xyz_t                xyz_in;

	// Channel state as read during the scan.
	logic [CTL_W-1:0]              ctl_rdata;
	logic [LV_W-1:0]               idx_eff;
	logic [codo_pkg::LIMIT_W-1:0]  lim_eff;
	logic [LV_W:0]                 nxt;
	logic                          can_step;
	logic [XYZ_W-1:0]              sum_rdata;
	codo_pkg::xyz_t                psum_eff;
	logic [XYZ_W-1:0]              tbl_rdata;
	codo_pkg::xyz_t                tbl_xyz;
	logic [CNT_W-1:0]              c_plus1;

	// Memory ports.
	logic                          ctl_we;
	logic [CH_W-1:0]               ctl_waddr;
	logic [CTL_W-1:0]              ctl_wdata;
	logic                          scan_re;
	logic [CH_W-1:0]               scan_raddr;
	logic                          sum_we;
	logic [CH_W-1:0]               sum_waddr;
	codo_pkg::xyz_t                sum_wdata;
	logic                          tbl_we;
	logic                          tbl_re;
	logic [TBL_AW-1:0]             tbl_waddr;
	logic [TBL_AW-1:0]             tbl_raddr;

	// Shared saturating adder.
	logic [codo_pkg::DATA_W-1:0]   add_a;
	logic [codo_pkg::DATA_W-1:0]   add_b;
	logic [codo_pkg::DATA_W-1:0]   add_s;

	// ------------------------------------------------------------------
	// Request decode. A request is taken only while the sequencer idles.
	// ------------------------------------------------------------------
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	// Sets past the channels and loads past the channels or levels are dropped.
	assign ch_ok   = 32'(channel) < MAX_CHANNELS;
	assign lv_ok   = 32'(level) < MAX_LEVELS;
	assign ch_idx  = CH_W'(channel);
	// A set level past the last level is clamped to the last level.
	assign set_idx = lv_ok ? LV_W'(level) : LV_W'(MAX_LEVELS - 1);
	assign xyz_in  = {z_in, y_in, x_in};

	// The channel count saturates at the number of implemented channels.
	assign n_w = (32'(count_q) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(count_q);

	assign start_scan = accept && (op == codo_pkg::OP_ADVANCE) && (n_w != '0);

	// ------------------------------------------------------------------
	// Scan step. A channel whose control entry was never written reads as
	// level 0 and limit 1; one whose partial sum was never written reads as zero.
	// ------------------------------------------------------------------
	assign idx_eff  = ctl_vld_q[c_q] ? ctl_rdata[LV_W-1:0] : '0;
	assign lim_eff  = ctl_vld_q[c_q] ? ctl_rdata[CTL_W-1:LV_W] : codo_pkg::LIMIT_W'(1);
	assign nxt      = {1'b0, idx_eff} + (LV_W + 1)'(1);
	// A channel steps only while the next level is below its own limit and
	// below the number of implemented levels.
	assign can_step = (32'(nxt) < 32'(lim_eff)) && (32'(nxt) < MAX_LEVELS);
	assign psum_eff = sum_vld_q[c_q] ? codo_pkg::xyz_t'(sum_rdata) : '0;
	assign tbl_xyz  = codo_pkg::xyz_t'(tbl_rdata);
	assign c_plus1  = CNT_W'(c_q) + CNT_W'(1);

	// Channel control memory: level limit above level index.
	always_comb begin
		ctl_we    = 1'b0;
		ctl_waddr = ch_idx;
		ctl_wdata = {level_limit_in, set_idx};
		if (state_q == S_EVAL) begin
			// Write back the stepped index, or level 0 when the channel wraps.
			ctl_we    = 1'b1;
			ctl_waddr = c_q;
			ctl_wdata = {lim_eff, can_step ? nxt[LV_W-1:0] : LV_W'(0)};
		end else if (accept && (op == codo_pkg::OP_SET) && ch_ok) begin
			ctl_we = 1'b1;
		end
	end

	// The control and partial sum memories are read together, one channel
	// per cycle: the last active channel at acceptance, then the one below
	// while the scan keeps wrapping.
	always_comb begin
		scan_re    = 1'b0;
		scan_raddr = CH_W'(n_w - CNT_W'(1));
		if (state_q == S_EVAL) begin
			scan_re    = !can_step && (c_q != '0);
			scan_raddr = c_q - CH_W'(1);
		end else if (start_scan) begin
			scan_re = 1'b1;
		end
	end

	// Partial sum memory: written by a set, and by the copy sweep that
	// hands the new sum to every later active channel.
	always_comb begin
		sum_we    = 1'b0;
		sum_waddr = ch_idx;
		sum_wdata = xyz_in;
		if (state_q == S_COPY) begin
			sum_we    = 1'b1;
			sum_waddr = j_q[CH_W-1:0];
			sum_wdata = res_q;
		end else if (accept && (op == codo_pkg::OP_SET) && ch_ok) begin
			sum_we = 1'b1;
		end
	end

	// Level table: written by a load, read at the stepped level.
	assign tbl_we    = accept && (op == codo_pkg::OP_LOAD) && ch_ok && lv_ok;
	assign tbl_waddr = {ch_idx, LV_W'(level)};
	assign tbl_re    = (state_q == S_EVAL) && can_step;
	assign tbl_raddr = {c_q, nxt[LV_W-1:0]};

	codo_ram #(
		.WIDTH (CTL_W),
		.DEPTH (MAX_CHANNELS)
	) u_ctl_ram (
		.clk   (clk),
		.we    (ctl_we),
		.waddr (ctl_waddr),
		.wdata (ctl_wdata),
		.re    (scan_re),
		.raddr (scan_raddr),
		.rdata (ctl_rdata)
	);

	codo_ram #(
		.WIDTH (XYZ_W),
		.DEPTH (MAX_CHANNELS)
	) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (XYZ_W'(sum_wdata)),
		.re    (scan_re),
		.raddr (scan_raddr),
		.rdata (sum_rdata)
	);

	codo_ram #(
		.WIDTH (XYZ_W),
		.DEPTH (2 ** TBL_AW)
	) u_tbl_ram (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (XYZ_W'(xyz_in)),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// One saturating adder handles X, Y and Z in turn.
	assign add_a = psum_q[lane_q];
	assign add_b = tbl_xyz[lane_q];

	codo_sat_add u_add (
		.a (add_a),
		.b (add_b),
		.s (add_s)
	);

	// ------------------------------------------------------------------
	// Configuration register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= codo_pkg::COUNT_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// Valid bits: a channel becomes valid on its first control or sum write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_vld_q <= '0;
			sum_vld_q <= '0;
		end else begin
			if (ctl_we) begin
				ctl_vld_q[ctl_waddr] <= 1'b1;
			end
			if (sum_we) begin
				sum_vld_q[sum_waddr] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
			c_q     <= '0;
			j_q     <= '0;
			lane_q  <= '0;
			fnd_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						fnd_q <= 1'b0;
						n_q   <= n_w;
						c_q   <= CH_W'(n_w - CNT_W'(1));
						if (start_scan) begin
							state_q <= S_EVAL;
						end else begin
							// Load, set, unused op, or an advance with no channels.
							state_q <= S_FIN;
						end
					end
				end
				S_EVAL: begin
					if (can_step) begin
						lane_q  <= '0;
						state_q <= S_ADD;
					end else if (c_q == '0) begin
						// Every active channel wrapped.
						state_q <= S_FIN;
					end else begin
						c_q <= c_q - CH_W'(1);
					end
				end
				S_ADD: begin
					lane_q <= lane_q + codo_pkg::LANE_W'(1);
					if (lane_q == LANE_LAST) begin
						fnd_q <= 1'b1;
						j_q   <= c_plus1;
						if (c_plus1 < n_q) begin
							state_q <= S_COPY;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_COPY: begin
					j_q <= j_q + CNT_W'(1);
					if (j_q == n_q - CNT_W'(1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operand and result registers of the adder.
	always_ff @(posedge clk) begin
		if ((state_q == S_EVAL) && can_step) begin
			psum_q <= psum_eff;
		end
		if (state_q == S_ADD) begin
			res_q[lane_q] <= add_s;
		end
	end

	// ------------------------------------------------------------------
	// Output register. It is loaded when the item finishes and the slot is
	// free or being emptied in the same cycle.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_found_q <= 1'b0;
		end else if ((state_q == S_FIN) && (!rsp_valid_q || !rsp_stall)) begin
			rsp_valid_q <= 1'b1;
			rsp_found_q <= fnd_q;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FIN) && (!rsp_valid_q || !rsp_stall)) begin
			// Sums are zero whenever no new combination was found.
			rsp_sum_q <= fnd_q ? res_q : '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign found     = rsp_found_q;
	assign sum_x     = rsp_sum_q[0];
	assign sum_y     = rsp_sum_q[1];
	assign sum_z     = rsp_sum_q[2];

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_nofound_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> (sum_x == '0) && (sum_y == '0) && (sum_z == '0))
		else $error("result without a combination carries nonzero sums");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> CNT_W'(c_q) < n_q)
		else $error("scan channel beyond the active channel count");

	a_copy_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COPY |-> (j_q < n_q) && (j_q > CNT_W'(c_q)))
		else $error("copy sweep outside the later active channels");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) && !req_valid |=> state_q == S_IDLE)
		else $error("sequencer left idle without an accepted item");

	a_found_has_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) && fnd_q |-> $past(state_q) == S_ADD || $past(state_q) == S_COPY
			|| $past(state_q) == S_FIN)
		else $error("found result without an addition");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for combo_odometer_with_partial_sums_core
// Drives load, set, advance and unused op items through the request channel
// with random gaps and stalls, predicts every result item with its own model
// of the odometer, and compares each result item field by field in order.
// ----------------------------------------------------------------------------

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import codo_pkg::*;

	// Sizes of the block as instantiated.
	localparam int MAX_CH = 16;
	localparam int MAX_LV = 64;

	// Op value 3 has no meaning in the block; it must give an empty result item.
	localparam logic [OP_W-1:0] OP_NONE = 2'd3;

	// The longest advance scans all 16 channels and copies its sum to the other 15.
	localparam int SETTLE_CYCLES = 40;
	// Length of the deliberate back-pressure stretch on the result side.
	localparam int LONG_HOLD_CYCLES = 300;
	// 8 ms at 10 ns per cycle is far beyond the slowest legal run.
	localparam int RUN_LIMIT_NS = 8_000_000;

	// One request item as the generator sees it. Lane 0 of xyz is X.
	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] level;
		logic [LIMIT_W-1:0] limit;
		xyz_t               xyz;
	} odo_req_t;

	// One result item: the found flag and the saturated XYZ of the combination.
	typedef struct packed {
		logic found;
		xyz_t sum;
	} odo_sum_t;

	// Clock and reset. Reset is asserted from time zero and then released for good.
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always #5 clk = ~clk;

	// Block inputs, all known from time zero.
	logic                 cfg_wr_en = 1'b0;
	logic [COUNT_W-1:0]   cfg_wr_data = '0;
	logic                 req_valid = 1'b0;
	logic [OP_W-1:0]      op = '0;
	logic [CHAN_W-1:0]    channel = '0;
	logic [LEVEL_W-1:0]   level = '0;
	logic [LIMIT_W-1:0]   level_limit_in = '0;
	logic [DATA_W-1:0]    x_in = '0;
	logic [DATA_W-1:0]    y_in = '0;
	logic [DATA_W-1:0]    z_in = '0;
	logic                 rsp_stall = 1'b0;

	// Block outputs.
	logic                 req_stall;
	logic                 rsp_valid;
	logic                 found;
	logic [DATA_W-1:0]    sum_x;
	logic [DATA_W-1:0]    sum_y;
	logic [DATA_W-1:0]    sum_z;

	combo_odometer_with_partial_sums_core #(
		.MAX_CHANNELS(MAX_CH),
		.MAX_LEVELS  (MAX_LV)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.op            (op),
		.channel       (channel),
		.level         (level),
		.level_limit_in(level_limit_in),
		.x_in          (x_in),
		.y_in          (y_in),
		.z_in          (z_in),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.found         (found),
		.sum_x         (sum_x),
		.sum_y         (sum_y),
		.sum_z         (sum_z)
	);

	// ------------------------------------------------------------------------
	// Odometer model. It holds its own copy of the channel state, the level
	// table and the channel count, and is stepped once per accepted item.
	// ------------------------------------------------------------------------
	logic [LEVEL_W-1:0] lvl_idx  [MAX_CH] = '{default: '0};
	logic [LIMIT_W-1:0] lvl_lim  [MAX_CH] = '{default: 7'd1};
	xyz_t               part_sum [MAX_CH] = '{default: '0};
	xyz_t               level_tbl[MAX_CH * MAX_LV];
	logic [COUNT_W-1:0] active_count = COUNT_RESET;

	// Applies one request item to the model and returns the result item it
	// must produce. Only an advance that finds a channel able to step gives
	// found = 1; everything else returns zeros.
	function automatic odo_sum_t odometer_step(odo_req_t rq);
		odo_sum_t           res;
		xyz_t               sum;
		logic [DATA_W:0]    wide;
		logic [LIMIT_W-1:0] nxt;
		logic [CHAN_W-1:0]  cc;
		int                 n;
		int                 c;
		int                 j;
		res = '0;
		sum = '0;
		case (rq.op)
			OP_LOAD: begin
				level_tbl[{rq.channel, rq.level}] = rq.xyz;
			end
			OP_SET: begin
				lvl_idx[rq.channel]  = rq.level;
				lvl_lim[rq.channel]  = rq.limit;
				part_sum[rq.channel] = rq.xyz;
			end
			OP_ADVANCE: begin
				// A count above the channel array saturates at its size.
				n = (active_count > MAX_CH) ? MAX_CH : active_count;
				// Scan from the last active channel down; channels at their
				// limit roll back to level 0 until one can step.
				for (c = n - 1; c >= 0; c--) begin
					if (!res.found) begin
						cc  = c[CHAN_W-1:0];
						nxt = {1'b0, lvl_idx[c]} + 1'b1;
						if (nxt < lvl_lim[c] && nxt < MAX_LV) begin
							lvl_idx[c] = nxt[LEVEL_W-1:0];
							for (j = 0; j < LANES; j++) begin
								wide = {1'b0, part_sum[c][j]} +
									{1'b0, level_tbl[{cc, nxt[LEVEL_W-1:0]}][j]};
								sum[j] = wide[DATA_W] ? '1 : wide[DATA_W-1:0];
							end
							// The new sum becomes the base of every later active channel.
							for (j = c + 1; j < n; j++)
								part_sum[j] = sum;
							res.found = 1'b1;
							res.sum   = sum;
						end else begin
							lvl_idx[c] = '0;
						end
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Shared bench state.
	// ------------------------------------------------------------------------
	odo_req_t request_q[$];      // items waiting to be offered to the block
	odo_sum_t expected_sums[$];  // predicted result items, oldest first
	int       reqs_queued = 0;   // items put into request_q so far
	int       reqs_taken  = 0;   // items accepted by the block so far
	int       err_count   = 0;
	int       src_gap_max = 0;   // largest idle gap the sender draws per item
	int       snk_gap_max = 0;   // largest stall the receiver draws per item
	int       holds_asked = 0;   // long result-side hold-offs requested
	bit       tbl_loaded[MAX_CH * MAX_LV];

	// ------------------------------------------------------------------------
	// Request driver. Each time an offered item is taken at this edge it draws
	// a random idle gap of up to src_gap_max, lets it run out with nothing
	// offered, and then offers the next item. An offered item holds still while
	// the block stalls. Each accepted item is run through the model right away,
	// so the expectation exists well before its result item can appear.
	// ------------------------------------------------------------------------
	int src_gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		odo_req_t acc_rq;
		odo_req_t nxt_rq;
		int       gap;
		if (!arst_n) begin
			req_valid    <= 1'b0;
			src_gap_left <= 0;
		end else begin
			if (req_valid && !req_stall) begin
				acc_rq.op      = op;
				acc_rq.channel = channel;
				acc_rq.level   = level;
				acc_rq.limit   = level_limit_in;
				acc_rq.xyz     = {z_in, y_in, x_in};
				expected_sums.push_back(odometer_step(acc_rq));
				reqs_taken++;
			end
			if (!req_valid || !req_stall) begin
				// A fresh gap is drawn only right after an acceptance.
				gap = req_valid ? $urandom_range(0, src_gap_max) : src_gap_left;
				if (gap != 0) begin
					src_gap_left <= gap - 1;
					req_valid    <= 1'b0;
				end else if (request_q.size() != 0) begin
					nxt_rq = request_q.pop_front();
					op             <= nxt_rq.op;
					channel        <= nxt_rq.channel;
					level          <= nxt_rq.level;
					level_limit_in <= nxt_rq.limit;
					x_in           <= nxt_rq.xyz[0];
					y_in           <= nxt_rq.xyz[1];
					z_in           <= nxt_rq.xyz[2];
					req_valid      <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Long hold-off on the result side. Each request from the sequence below
	// raises long_hold for the stretch set by LONG_HOLD_CYCLES, counted down here, so the block
	// fills up with one finished result item and stalls its request side.
	// ------------------------------------------------------------------------
	logic long_hold = 1'b0;
	int   hold_count = 0;
	int   holds_done = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold  <= 1'b0;
			hold_count <= 0;
			holds_done <= 0;
		end else if (hold_count != 0) begin
			hold_count <= hold_count - 1;
			long_hold  <= (hold_count > 1);
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_count <= LONG_HOLD_CYCLES;
			long_hold  <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor and receiver. Every accepted result item is checked
	// against the oldest expectation; after it the receiver draws a random
	// stall of up to snk_gap_max. The stall also runs while nothing is valid, so
	// it lands on every phase of the block's work.
	// ------------------------------------------------------------------------
	int snk_hold_left = 0;

	task automatic check_field(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		odo_sum_t want;
		int       hold;
		if (!arst_n) begin
			rsp_stall     <= 1'b0;
			snk_hold_left <= 0;
		end else begin
			hold = snk_hold_left;
			if (rsp_valid && !rsp_stall) begin
				if (expected_sums.size() == 0) begin
					$display("%0t: result item with nothing expected, found %0b sums %h %h %h",
						$time, found, sum_x, sum_y, sum_z);
					err_count++;
				end else begin
					want = expected_sums.pop_front();
					check_field("found", {{(DATA_W-1){1'b0}}, want.found},
						{{(DATA_W-1){1'b0}}, found});
					check_field("sum_x", want.sum[0], sum_x);
					check_field("sum_y", want.sum[1], sum_y);
					check_field("sum_z", want.sum[2], sum_z);
				end
				hold = $urandom_range(0, snk_gap_max);
			end else if (hold != 0) begin
				hold--;
			end
			snk_hold_left <= hold;
			rsp_stall     <= long_hold || (hold != 0);
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------

	// Q16.16 values biased toward the edges so that saturation is common.
	function automatic logic [DATA_W-1:0] rand_q16();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return 32'hFFFF_0000 | $urandom_range(0, 32'hFFFF);
			3:       return $urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic xyz_t rand_xyz();
		return {rand_q16(), rand_q16(), rand_q16()};
	endfunction

	task automatic push_req(input logic [OP_W-1:0] o, input logic [CHAN_W-1:0] ch,
			input logic [LEVEL_W-1:0] lv, input logic [LIMIT_W-1:0] lim, input xyz_t v);
		odo_req_t rq;
		rq.op      = o;
		rq.channel = ch;
		rq.level   = lv;
		rq.limit   = lim;
		rq.xyz     = v;
		if (o == OP_LOAD)
			tbl_loaded[{ch, lv}] = 1'b1;
		request_q.push_back(rq);
		reqs_queued++;
	endtask

	// An advance only ever reads levels from 1 to below the channel's limit (capped at
	// the table depth), so before a set gives a channel its limit, every level
	// it can reach is loaded. No advance can then read an unwritten entry.
	task automatic set_channel(input logic [CHAN_W-1:0] ch, input logic [LEVEL_W-1:0] lv,
			input logic [LIMIT_W-1:0] lim, input xyz_t v);
		int top;
		int l;
		top = (lim > MAX_LV) ? MAX_LV : lim;
		for (l = 1; l < top; l++)
			if (!tbl_loaded[{ch, l[LEVEL_W-1:0]}])
				push_req(OP_LOAD, ch, l[LEVEL_W-1:0], LIMIT_W'($urandom), rand_xyz());
		push_req(OP_SET, ch, lv, lim, v);
	endtask

	// Mostly short radices so that wraps and carries happen often; now and
	// then a deep channel, a limit of zero or one, or a limit past the table.
	task automatic random_set(input logic [CHAN_W-1:0] ch);
		logic [LIMIT_W-1:0] lim;
		logic [LEVEL_W-1:0] lv;
		int                 r;
		r = $urandom_range(0, 99);
		if (r < 72)
			lim = LIMIT_W'($urandom_range(2, 4));
		else if (r < 84)
			lim = LIMIT_W'($urandom_range(5, 12));
		else if (r < 87)
			lim = LIMIT_W'($urandom_range(13, MAX_LV));
		else if (r < 92)
			lim = LIMIT_W'(0);
		else if (r < 96)
			lim = LIMIT_W'(1);
		else
			lim = LIMIT_W'($urandom_range(MAX_LV + 1, 127));
		lv = ($urandom_range(0, 99) < 70) ? '0 : LEVEL_W'($urandom_range(0, MAX_LV - 1));
		set_channel(ch, lv, lim, rand_xyz());
	endtask

	// Blocks until every queued item has been accepted and answered. Each item
	// gives exactly one result item, so the block is idle afterwards.
	task automatic wait_drained();
		while (reqs_taken != reqs_queued || expected_sums.size() != 0)
			@(posedge clk);
	endtask

	// The channel count is only written while the block is idle.
	task automatic write_count(input logic [COUNT_W-1:0] v);
		wait_drained();
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		active_count = v;
	endtask

	// One random phase: configure, give every active channel a fresh state,
	// then mostly advances, with reloads, re-sets and unused ops mixed in.
	task automatic run_phase(input logic [COUNT_W-1:0] cnt, input int n_items,
			input int src_max, input int snk_max, input bit with_long_hold);
		int n;
		int stop;
		int ch;
		int r;
		write_count(cnt);
		src_gap_max = src_max;
		snk_gap_max = snk_max;
		if (with_long_hold)
			holds_asked++;
		n    = (cnt > MAX_CH) ? MAX_CH : cnt;
		stop = reqs_queued + n_items;
		for (ch = 0; ch < n; ch++)
			random_set(ch[CHAN_W-1:0]);
		while (reqs_queued < stop) begin
			r = $urandom_range(0, 99);
			if (r < 68 || r >= 95)
				push_req(OP_ADVANCE, CHAN_W'($urandom), LEVEL_W'($urandom),
					LIMIT_W'($urandom), rand_xyz());
			else if (r < 78)
				push_req(OP_LOAD, CHAN_W'($urandom), LEVEL_W'($urandom),
					LIMIT_W'($urandom), rand_xyz());
			else if (r < 90)
				random_set(CHAN_W'((r < 85 && n > 0) ? $urandom_range(0, n - 1) :
					$urandom_range(0, 15)));
			else
				push_req(OP_NONE, CHAN_W'($urandom), LEVEL_W'($urandom),
					LIMIT_W'($urandom), rand_xyz());
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, with the channel count still at its reset value of 1.
		src_gap_max = 2;
		snk_gap_max = 2;
		// Every channel comes out of reset with limit 1, so it wraps at once.
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		// The unused op code answers with an empty result item.
		push_req(OP_NONE, '1, '1, '1, '1);
		push_req(OP_LOAD, 4'd0, 6'd1, '0, {32'h0000_1000, 32'h8000_0000, 32'hFFFF_FFFF});
		push_req(OP_LOAD, 4'd15, 6'd63, '1, '1);
		push_req(OP_LOAD, 4'd0, 6'd0, '0, '0);
		// X saturates, Y lands exactly on all ones, Z adds without carry.
		set_channel(4'd0, 6'd0, 7'd2, {32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0001});
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		// Channel at its limit with no other channel: full wrap.
		push_req(OP_ADVANCE, '1, '1, '1, '1);
		// Index set beyond the limit wraps on the next advance.
		set_channel(4'd0, 6'd63, 7'd2, {32'h1234_5678, 32'h0000_0010, 32'hFFFF_FFF0});
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		// A limit of zero never lets the channel step.
		set_channel(4'd0, 6'd0, 7'd0, '1);
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		// No active channels at all.
		write_count(5'd0);
		push_req(OP_ADVANCE, '0, '0, '0, '0);
		// Two channels: carries from channel 1 into channel 0 and the new
		// partial sum handed back to channel 1.
		write_count(5'd2);
		set_channel(4'd0, 6'd0, 7'd3, {32'h0003_0000, 32'h0002_0000, 32'h0001_0000});
		set_channel(4'd1, 6'd0, 7'd2, {32'h0000_8000, 32'h0000_4000, 32'h0000_2000});
		repeat (5)
			push_req(OP_ADVANCE, '0, '0, '0, '0);

		// Random phases. The count goes through both extremes, zero and values
		// past the channel array. Some phases idle hard, some not at all; one
		// holds the result side off for a long stretch while items keep coming.
		// Every phase starts only after the previous one has fully drained.
		run_phase(5'd16, 250, 15, 15, 1'b0);
		run_phase(5'd31, 240,  0,  0, 1'b0);
		run_phase(5'd3,  230, 15,  0, 1'b0);
		run_phase(5'd1,  190,  0, 15, 1'b0);
		run_phase(5'd17, 230,  0,  0, 1'b1);
		run_phase(5'd0,   40,  3,  3, 1'b0);
		run_phase(5'd2,  230, 15, 15, 1'b0);
		run_phase(5'd8,  250,  0,  0, 1'b0);
		run_phase(COUNT_W'($urandom_range(1, MAX_CH)), 250, 15, 15, 1'b0);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_sums.size() != 0)
			$display("%0t: %0d expected result items never arrived", $time,
				expected_sums.size());
		if (err_count == 0 && expected_sums.size() == 0) begin
			$display("combo_odometer_with_partial_sums_core test passed");
		end else begin
			$display("combo_odometer_with_partial_sums_core test failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("%0t: run did not finish in time", $time);
		$display("combo_odometer_with_partial_sums_core test failed");
		$finish;
	end

endmodule

// ===== combo_odometer_with_partial_sums_core.f =====
rtl/codo_pkg.sv
rtl/codo_ram.sv
rtl/codo_sat_add.sv
rtl/combo_odometer_with_partial_sums_core.sv
verif/testbench.sv
